// ----- src/sdss_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the spike delay slot scheduler.
package sdss_pkg;

  localparam int unsigned SlotCountDef = 16;
  localparam int unsigned AxonCountDef = 256;
  localparam int unsigned ChunkW       = 64;
  localparam int unsigned MaxChunks    = 4;
  localparam int unsigned DelayW       = 4;
  localparam int unsigned DelayCount   = 2 ** DelayW;
  localparam int unsigned AxonIdxW     = 8;
  localparam int unsigned ChunkIdxW    = 2;

  typedef enum logic [1:0] {
    StStored    = 2'd0,
    StRefused   = 2'd1,
    StDuplicate = 2'd2,
    StChunk     = 2'd3
  } status_e;

  typedef struct packed {
    logic                mode;
    logic [DelayW-1:0]   delay_offset;
    logic [AxonIdxW-1:0] axon_index;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [ChunkW-1:0]    chunk_bits;
    logic [ChunkIdxW-1:0] chunk_index;
    logic                 last;
  } out_item_t;

  // Control of the item held in the execute stage.
  typedef struct packed {
    logic vld;
    logic tick;
    logic refused;
  } stage_ctl_t;

endpackage

// ----- src/sdss_issue.sv -----
`timescale 1ns / 1ps
// Issue stage: target slot arithmetic, current slot pointer and execute-stage register.
module sdss_issue #(
  parameter int unsigned SLOT_COUNT = sdss_pkg::SlotCountDef,
  parameter int unsigned AXON_COUNT = sdss_pkg::AxonCountDef,
  parameter int unsigned SLOT_W     = $clog2(SLOT_COUNT)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sdss_pkg::in_item_t             in_item_i,
  input  logic                           b_done_i,
  output logic [SLOT_W-1:0]              rd_slot_o,
  output logic                           rd_en_o,
  output sdss_pkg::stage_ctl_t           b_ctl_o,
  output logic [SLOT_W-1:0]              b_slot_o,
  output logic [sdss_pkg::AxonIdxW-1:0]  b_axon_o
);
  import sdss_pkg::*;

  logic [SLOT_W-1:0] doff_tbl [DelayCount];
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [SLOT_W-1:0] doff;
  logic [SLOT_W:0]   sum;
  logic [SLOT_W-1:0] target;
  logic              refused;
  logic              accept;
  stage_ctl_t        ctl_q, ctl_d;
  logic [SLOT_W-1:0] slot_q;
  logic [AxonIdxW-1:0] axon_q;

  // (delay + 1) mod slot count, worked out at elaboration
  for (genvar g = 0; g < DelayCount; g++) begin : g_doff
    localparam int unsigned Doff = (g + 1) % SLOT_COUNT;
    assign doff_tbl[g] = SLOT_W'(Doff);
  end

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = ~ctl_q.vld | b_done_i;

  assign doff   = doff_tbl[in_item_i.delay_offset];
  assign sum    = {1'b0, cur_q} + {1'b0, doff};
  assign target = (sum >= (SLOT_W+1)'(SLOT_COUNT)) ?
                  SLOT_W'(sum - (SLOT_W+1)'(SLOT_COUNT)) : SLOT_W'(sum);

  // Target equal to current slot, or an axon at or beyond AXON_COUNT: refuse
  assign refused = (doff == '0) || (32'(in_item_i.axon_index) >= AXON_COUNT);

  always_comb begin
    cur_d = cur_q;
    if (accept && in_item_i.mode) begin
      cur_d = (cur_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : cur_q + SLOT_W'(1);
    end
  end

  assign rd_slot_o = in_item_i.mode ? cur_d : target;
  assign rd_en_o   = accept;

  always_comb begin
    ctl_d = ctl_q;
    if (accept) begin
      ctl_d.vld     = 1'b1;
      ctl_d.tick    = in_item_i.mode;
      ctl_d.refused = ~in_item_i.mode & refused;
    end else if (b_done_i) begin
      ctl_d.vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= SLOT_W'(SLOT_COUNT - 1);
      ctl_q <= '0;
    end else begin
      cur_q <= cur_d;
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q <= rd_slot_o;
      axon_q <= in_item_i.axon_index;
    end
  end

  assign b_ctl_o  = ctl_q;
  assign b_slot_o = slot_q;
  assign b_axon_o = axon_q;

endmodule

// ----- src/sdss_store.sv -----
`timescale 1ns / 1ps
// Slot word memory with per-slot valid bits and write-to-read bypass.
module sdss_store #(
  parameter int unsigned SLOT_COUNT = sdss_pkg::SlotCountDef,
  parameter int unsigned SLOT_W     = $clog2(SLOT_COUNT),
  parameter int unsigned ROW_W      = sdss_pkg::AxonCountDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [SLOT_W-1:0] rd_slot_i,
  input  logic              wr_en_i,
  input  logic [SLOT_W-1:0] wr_slot_i,
  input  logic [ROW_W-1:0]  wr_row_i,
  output logic [ROW_W-1:0]  rd_row_o
);
  import sdss_pkg::*;

  logic [ROW_W-1:0]      mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_q;
  logic [ROW_W-1:0]      rd_q;
  logic                  rd_valid_q;
  logic                  byp_q;
  logic [ROW_W-1:0]      byp_row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_slot_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_q      <= mem[rd_slot_i];
      byp_row_q <= wr_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_slot_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_slot_i];
        byp_q      <= wr_en_i && (wr_slot_i == rd_slot_i);
      end
    end
  end

  // A slot never written since reset reads as all zeros
  assign rd_row_o = byp_q ? byp_row_q : (rd_valid_q ? rd_q : '0);

endmodule

// ----- src/sdss_exec.sv -----
`timescale 1ns / 1ps
// Execute stage: duplicate check, row update, chunk sequencing and result register.
module sdss_exec #(
  parameter int unsigned SLOT_W = 4,
  parameter int unsigned CHUNKS = sdss_pkg::MaxChunks,
  parameter int unsigned ROW_W  = CHUNKS * sdss_pkg::ChunkW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sdss_pkg::stage_ctl_t          b_ctl_i,
  input  logic [SLOT_W-1:0]             b_slot_i,
  input  logic [sdss_pkg::AxonIdxW-1:0] b_axon_i,
  input  logic [ROW_W-1:0]              row_i,
  output logic                          b_done_o,
  output logic                          wr_en_o,
  output logic [SLOT_W-1:0]             wr_slot_o,
  output logic [ROW_W-1:0]              wr_row_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sdss_pkg::out_item_t           out_item_o
);
  import sdss_pkg::*;

  localparam int unsigned CntW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned BitW = $clog2(ROW_W);

  logic [CHUNKS-1:0][ChunkW-1:0] row_chunks;
  logic [CntW-1:0]  chunk_q;
  logic             last_chunk;
  logic             out_free;
  logic             step;
  logic [ROW_W-1:0] mask;
  logic             hit;
  logic             out_vld_q;
  out_item_t        out_q, res;

  assign row_chunks = row_i;
  assign out_free   = ~out_vld_q | out_ready_i;
  assign step       = b_ctl_i.vld & out_free;
  assign last_chunk = (chunk_q == CntW'(CHUNKS - 1));
  assign b_done_o   = step & (~b_ctl_i.tick | last_chunk);

  assign mask = ROW_W'(1) << b_axon_i[BitW-1:0];
  assign hit  = |(row_i & mask);

  always_comb begin
    res = '0;
    if (b_ctl_i.tick) begin
      res.status      = StChunk;
      res.chunk_bits  = row_chunks[chunk_q];
      res.chunk_index = ChunkIdxW'(chunk_q);
      res.last        = last_chunk;
    end else begin
      res.last = 1'b1;
      if (b_ctl_i.refused) begin
        res.status = StRefused;
      end else if (hit) begin
        res.status = StDuplicate;
      end else begin
        res.status = StStored;
      end
    end
  end

  // Tick clears the word once its last chunk leaves; a fresh spike sets its bit
  assign wr_en_o   = b_done_o & (b_ctl_i.tick | (~b_ctl_i.refused & ~hit));
  assign wr_slot_o = b_slot_i;
  assign wr_row_o  = b_ctl_i.tick ? '0 : (row_i | mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (step && b_ctl_i.tick) begin
        chunk_q <= last_chunk ? '0 : chunk_q + CntW'(1);
      end
      if (out_free) begin
        out_vld_q <= b_ctl_i.vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ----- src/spike_delay_slot_scheduler.sv -----
`timescale 1ns / 1ps
// Top level of the spike delay slot scheduler (timing wheel).
//
// A ring of SLOT_COUNT slot words, one bit per axon. A spike item (mode 0) sets
// its axon bit in slot (current + delay_offset + 1) mod SLOT_COUNT and returns
// one result: stored, refused (target is the current slot, or the axon lies
// at or beyond AXON_COUNT) or duplicate (bit already set). A tick item (mode 1)
// advances the current slot, emits the new current word as ceil(AXON_COUNT/64)
// chunks of 64 bits (at most four, lowest axons first, last flagged) and then
// clears that word. Flow: an item passes an issue register, where the target
// slot is formed and the slot memory is read, and an execute stage that
// updates the row and loads the result register. Spikes are taken one per
// cycle, back to back, while the output is not stalled, even when they hit
// the same slot (the row written by one spike is bypassed to the next read).
// A tick holds the execute stage until its last chunk has left, and only then
// does the next item move on. Reset clears the store at once through a valid
// bit per slot; there is no clearing pass, and the block is ready as soon as
// reset is released.
module spike_delay_slot_scheduler #(
  parameter int unsigned SLOT_COUNT = sdss_pkg::SlotCountDef,
  parameter int unsigned AXON_COUNT = sdss_pkg::AxonCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdss_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sdss_pkg::out_item_t out_item_o
);
  import sdss_pkg::*;

  localparam int unsigned SlotW     = $clog2(SLOT_COUNT);
  localparam int unsigned RawChunks = (AXON_COUNT + ChunkW - 1) / ChunkW;
  localparam int unsigned Chunks    = (RawChunks > MaxChunks) ? MaxChunks : RawChunks;
  localparam int unsigned RowW      = Chunks * ChunkW;

  logic [SlotW-1:0]    rd_slot;
  logic                rd_en;
  stage_ctl_t          b_ctl;
  logic [SlotW-1:0]    b_slot;
  logic [AxonIdxW-1:0] b_axon;
  logic                b_done;
  logic [RowW-1:0]     row;
  logic                wr_en;
  logic [SlotW-1:0]    wr_slot;
  logic [RowW-1:0]     wr_row;

  // Issue: form the target slot, advance the pointer on a tick, start the read
  sdss_issue #(
    .SLOT_COUNT(SLOT_COUNT),
    .AXON_COUNT(AXON_COUNT),
    .SLOT_W    (SlotW)
  ) u_issue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i (in_item_i),
    .b_done_i  (b_done),
    .rd_slot_o (rd_slot),
    .rd_en_o   (rd_en),
    .b_ctl_o   (b_ctl),
    .b_slot_o  (b_slot),
    .b_axon_o  (b_axon)
  );

  // Store: slot words, valid bits, bypass of the write landing with the read
  sdss_store #(
    .SLOT_COUNT(SLOT_COUNT),
    .SLOT_W    (SlotW),
    .ROW_W     (RowW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_slot_i(rd_slot),
    .wr_en_i  (wr_en),
    .wr_slot_i(wr_slot),
    .wr_row_i (wr_row),
    .rd_row_o (row)
  );

  // Execute: check and set the bit, or walk the chunks and clear the word
  sdss_exec #(
    .SLOT_W(SlotW),
    .CHUNKS(Chunks),
    .ROW_W (RowW)
  ) u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .b_ctl_i    (b_ctl),
    .b_slot_i   (b_slot),
    .b_axon_i   (b_axon),
    .row_i      (row),
    .b_done_o   (b_done),
    .wr_en_o    (wr_en),
    .wr_slot_o  (wr_slot),
    .wr_row_o   (wr_row),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// ----- src/sdss_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the spike delay slot scheduler and their bind.
module sdss_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input sdss_pkg::out_item_t out_item_o
);
  import sdss_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Spike results are single, final and carry no word bits
  a_spike_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != StChunk) |->
      out_item_o.last && (out_item_o.chunk_bits == '0) && (out_item_o.chunk_index == '0))
    else $error("malformed spike result");

  // A taken non-final chunk is followed at once by the next chunk
  a_chunk_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (out_item_o.status == StChunk) && !out_item_o.last |=>
      out_valid_o && (out_item_o.status == StChunk) &&
      (out_item_o.chunk_index == $past(out_item_o.chunk_index) + 2'd1))
    else $error("tick chunks out of sequence");

  // No new item is taken while a stalled tick chunk still has chunks to follow
  a_tick_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && (out_item_o.status == StChunk) && !out_item_o.last
      |-> !in_ready_o)
    else $error("item accepted during tick emission");

endmodule

bind spike_delay_slot_scheduler sdss_checker u_sdss_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);
